[hdl/mkcc_pkg.sv]
// ----------------------------------------------------------------------------
// mkcc_pkg
// Shared types, constants and register codes of the multi-key click
// classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package mkcc_pkg;

  // Key count default and field widths
  localparam int NUM_KEYS_DEF = 3;
  localparam int LEVEL_W      = 3;
  localparam int TICK_W       = 8;
  localparam int COUNT_W      = 2;
  localparam int KIND_W       = 2;
  localparam int KEY_W        = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DOUBLE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_LONG   = 2'd3;

  // Saturation value of the press count
  localparam logic [COUNT_W-1:0] COUNT_MAX = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TICKS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_CAP      = 3'd4;

  // Register reset values
  localparam logic              RST_PRESS_LEVEL   = 1'b0;
  localparam logic [TICK_W-1:0] RST_DOUBLE_WINDOW = 8'd30;
  localparam logic [TICK_W-1:0] RST_LONG_TICKS    = 8'd100;
  localparam logic [TICK_W-1:0] RST_MIN_TICKS     = 8'd2;
  localparam logic [TICK_W-1:0] RST_HOLD_CAP      = 8'd120;

  typedef logic [KIND_W-1:0] kind_t;

  // Register file as seen by the lanes
  typedef struct packed {
    logic              press_level;
    logic [TICK_W-1:0] double_window;
    logic [TICK_W-1:0] long_ticks;
    logic [TICK_W-1:0] min_ticks;
    logic [TICK_W-1:0] hold_cap;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0] event_kind;
    logic [KEY_W-1:0]  event_key;
  } result_t;

endpackage

`default_nettype wire

[hdl/mkcc_if.sv]
// ----------------------------------------------------------------------------
// mkcc_if
// Valid/ready channels of the classifier: scan ticks in, events out and
// register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkcc_tick_if;
  logic                          valid;
  logic                          ready;
  logic [mkcc_pkg::LEVEL_W-1:0]  key_levels;

  modport source (output valid, output key_levels, input ready);
  modport sink   (input valid, input key_levels, output ready);
endinterface

interface mkcc_event_if;
  logic                          valid;
  logic                          ready;
  logic [mkcc_pkg::KIND_W-1:0]   event_kind;
  logic [mkcc_pkg::KEY_W-1:0]    event_key;

  modport source (output valid, output event_kind, output event_key, input ready);
  modport sink   (input valid, input event_kind, input event_key, output ready);
endinterface

interface mkcc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mkcc_pkg::CFG_IDX_W-1:0]  index;
  logic [mkcc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/mkcc_lane.sv]
// ----------------------------------------------------------------------------
// mkcc_lane
// Per-key classifier: hold counter, double-press window, press count and
// long-press block; reports the event kind this key raises on the tick.
// ----------------------------------------------------------------------------
`default_nettype none

module mkcc_lane (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic            level,
  input  wire mkcc_pkg::cfg_t  cfg,
  output mkcc_pkg::kind_t      kind
);

  localparam int TW = mkcc_pkg::TICK_W;

  logic [TW-1:0]                 hold_ticks, hold_ticks_next;
  logic [TW-1:0]                 window_ticks, window_ticks_next;
  logic [mkcc_pkg::COUNT_W-1:0]  press_count, press_count_next;
  logic                          long_blocked, long_blocked_next;

  logic          pressed;
  logic [TW:0]   hold_inc;
  logic          is_long;
  logic          is_short;
  logic [TW-1:0] win_load;
  logic [TW-1:0] win_dec;
  logic [mkcc_pkg::COUNT_W-1:0] count_load;

  assign pressed  = (level == cfg.press_level);
  assign hold_inc = {1'b0, hold_ticks} + {{TW{1'b0}}, 1'b1};
  assign is_long  = (hold_ticks >= cfg.long_ticks) && !long_blocked;
  assign is_short = !is_long && (hold_ticks >= cfg.min_ticks);

  // Classify the tick and work out the next lane state
  always_comb begin
    hold_ticks_next   = hold_ticks;
    window_ticks_next = window_ticks;
    press_count_next  = press_count;
    long_blocked_next = long_blocked;
    kind              = mkcc_pkg::KIND_NONE;
    win_load          = window_ticks;
    win_dec           = window_ticks;
    count_load        = press_count;
    if (pressed) begin
      // Count the hold up, saturating at the cap
      if (hold_inc >= {1'b0, cfg.hold_cap}) begin
        hold_ticks_next = cfg.hold_cap;
      end else begin
        hold_ticks_next = hold_inc[TW-1:0];
      end
    end else begin
      hold_ticks_next = '0;
      if (is_long) begin
        kind = mkcc_pkg::KIND_LONG;
      end
      // A short press bumps the count and reloads the window
      if (is_short) begin
        if (press_count != mkcc_pkg::COUNT_MAX) begin
          count_load = press_count + mkcc_pkg::COUNT_W'(1);
        end
        win_load          = cfg.double_window;
        long_blocked_next = 1'b1;
      end
      press_count_next  = count_load;
      window_ticks_next = win_load;
      // Run the window down on released ticks and report on expiry
      if (win_load != '0) begin
        win_dec           = win_load - TW'(1);
        window_ticks_next = win_dec;
        if (win_dec == '0) begin
          if (count_load == mkcc_pkg::COUNT_W'(1)) begin
            kind = mkcc_pkg::KIND_SINGLE;
          end else if (count_load == mkcc_pkg::COUNT_W'(2)) begin
            kind = mkcc_pkg::KIND_DOUBLE;
          end
          press_count_next  = '0;
          long_blocked_next = 1'b0;
        end
      end
    end
  end

  // Update the lane state on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks   <= '0;
      window_ticks <= '0;
      press_count  <= '0;
      long_blocked <= 1'b0;
    end else if (advance) begin
      hold_ticks   <= hold_ticks_next;
      window_ticks <= window_ticks_next;
      press_count  <= press_count_next;
      long_blocked <= long_blocked_next;
    end
  end

endmodule

`default_nettype wire

[hdl/mkcc_merge.sv]
// ----------------------------------------------------------------------------
// mkcc_merge
// Picks the highest-numbered key with an event and queues the result in a
// two-entry output buffer so ticks keep flowing while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module mkcc_merge #(
  parameter int NUM_KEYS = mkcc_pkg::NUM_KEYS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire mkcc_pkg::kind_t [NUM_KEYS-1:0] kinds,
  output logic                                full,
  mkcc_event_if.source                        events
);

  mkcc_pkg::result_t winner;
  mkcc_pkg::result_t head, tail;
  logic              head_valid, tail_valid;
  logic              pop;

  // Highest key with an event wins; key index keeps its low bits
  always_comb begin
    winner.event_kind = mkcc_pkg::KIND_NONE;
    winner.event_key  = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (kinds[k] != mkcc_pkg::KIND_NONE) begin
        winner.event_kind = kinds[k];
        winner.event_key  = mkcc_pkg::KEY_W'(k);
      end
    end
  end

  assign pop  = events.valid && events.ready;
  assign full = tail_valid;

  // Output queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else begin
      case ({push, pop})
        2'b11: ;
        2'b01: begin
          head_valid <= tail_valid;
          tail_valid <= 1'b0;
        end
        2'b10: begin
          if (head_valid) begin
            tail_valid <= 1'b1;
          end else begin
            head_valid <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output queue payload
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b11: begin
        if (tail_valid) begin
          head <= tail;
          tail <= winner;
        end else begin
          head <= winner;
        end
      end
      2'b01: head <= tail;
      2'b10: begin
        if (head_valid) begin
          tail <= winner;
        end else begin
          head <= winner;
        end
      end
      default: ;
    endcase
  end

  assign events.valid      = head_valid;
  assign events.event_kind = head.event_kind;
  assign events.event_key  = head.event_key;

endmodule

`default_nettype wire

[hdl/multi_key_click_classifier.sv]
// ----------------------------------------------------------------------------
// multi_key_click_classifier
// Single, double and long press detection over several keys per scan tick.
// ----------------------------------------------------------------------------
// Each item on keys is one scan tick with one level bit per key; every tick
// yields exactly one item on events, queued when the tick is taken (kind 0 when
// nothing happened). A tick is taken every cycle: all key lanes update in
// parallel in the accept cycle and the merge writes a two-entry output
// queue, so input stalls only when both queue entries wait on the sink.
// Keys above the three level bits read level 0. Register writes on cfg are
// always taken and must only be issued while no tick is in flight.
`default_nettype none

module multi_key_click_classifier #(
  parameter int NUM_KEYS = mkcc_pkg::NUM_KEYS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  mkcc_tick_if.sink    keys,
  mkcc_event_if.source events,
  mkcc_cfg_if.sink     cfg
);

  mkcc_pkg::cfg_t                   regs;
  mkcc_pkg::kind_t [NUM_KEYS-1:0]   kinds;
  logic                             advance;
  logic                             full;

  assign cfg.ready  = 1'b1;
  assign keys.ready = !full;
  assign advance    = keys.valid && keys.ready;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.press_level   <= mkcc_pkg::RST_PRESS_LEVEL;
      regs.double_window <= mkcc_pkg::RST_DOUBLE_WINDOW;
      regs.long_ticks    <= mkcc_pkg::RST_LONG_TICKS;
      regs.min_ticks     <= mkcc_pkg::RST_MIN_TICKS;
      regs.hold_cap      <= mkcc_pkg::RST_HOLD_CAP;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        mkcc_pkg::REG_PRESS_LEVEL:   regs.press_level   <= cfg.data[0];
        mkcc_pkg::REG_DOUBLE_WINDOW: regs.double_window <= cfg.data;
        mkcc_pkg::REG_LONG_TICKS:    regs.long_ticks    <= cfg.data;
        mkcc_pkg::REG_MIN_TICKS:     regs.min_ticks     <= cfg.data;
        mkcc_pkg::REG_HOLD_CAP:      regs.hold_cap      <= cfg.data;
        default: ;
      endcase
    end
  end

  // One lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic level;
    if (k < mkcc_pkg::LEVEL_W) begin : g_in
      assign level = keys.key_levels[k];
    end else begin : g_out
      assign level = 1'b0;
    end

    mkcc_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .level   (level),
      .cfg     (regs),
      .kind    (kinds[k])
    );
  end

  // Merge lane events and queue the result
  mkcc_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk    (clk),
    .rst    (rst),
    .push   (advance),
    .kinds  (kinds),
    .full   (full),
    .events (events)
  );

`ifndef SYNTHESIS
  // A result with no event never names a key
  assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == mkcc_pkg::KIND_NONE) |-> events.event_key == '0)
    else $error("event key set without an event");

  // Every accepted tick leaves a result waiting in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    keys.valid && keys.ready |=> events.valid)
    else $error("accepted tick produced no result");

  // Ticks stall only while results back up
  assert property (@(posedge clk) disable iff (rst)
    !keys.ready |-> events.valid && !$past(rst))
    else $error("tick input stalled with empty output queue");
`endif

endmodule

`default_nettype wire

[tb/multi_key_click_classifier_tb.sv]
// ----------------------------------------------------------------------------
// multi_key_click_classifier_tb
// Self-checking bench for the multi-key click classifier. A directed table
// covers single, double and long presses, saturated counts, the highest key
// winning, a lowered cap and a zero window. Random phases follow: each one
// sets new registers, then sends well-formed press and release sequences
// with some noise. Events check against typed rows or an in-bench classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_key_click_classifier_tb;

  localparam int NUM_KEYS   = mkcc_pkg::NUM_KEYS_DEF;
  localparam int NUM_PHASES = 11;
  localparam int PHASE_LEN  = 170;
  localparam int RUN_LIMIT  = 200000;

  // First register index that the block does not decode
  localparam logic [mkcc_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

  typedef enum logic {ROW_TICK, ROW_CFG} row_op_e;

  typedef struct packed {
    row_op_e                          op;
    logic [mkcc_pkg::CFG_IDX_W-1:0]   idx;
    logic [mkcc_pkg::CFG_DATA_W-1:0]  data;
    logic [mkcc_pkg::LEVEL_W-1:0]     levels;
    logic                             typed;
    mkcc_pkg::kind_t                  kind;
    logic [mkcc_pkg::KEY_W-1:0]       key;
  } row_t;

  localparam int DIR_ROWS = 37;

  // Directed rows; typed rows carry their event, the rest use the classifier
  localparam row_t DIR_TABLE [DIR_ROWS] = '{
    // reset state: all keys released, nothing to report
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b111, 1'b1, mkcc_pkg::KIND_NONE, 2'd0},
    // short timing, active-high keys, unknown index ignored
    '{ROW_CFG, mkcc_pkg::REG_PRESS_LEVEL, 8'd1, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_CFG, mkcc_pkg::REG_DOUBLE_WINDOW, 8'd2, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_CFG, mkcc_pkg::REG_LONG_TICKS, 8'd3, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_CFG, mkcc_pkg::REG_MIN_TICKS, 8'd1, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_CFG, mkcc_pkg::REG_HOLD_CAP, 8'd4, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_CFG, REG_UNUSED_FIRST, 8'hFF, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    // single press on key 0
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b001, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b1, mkcc_pkg::KIND_SINGLE, 2'd0},
    // long press on key 2
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b100, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b100, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b100, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b1, mkcc_pkg::KIND_LONG, 2'd2},
    // three presses on every key: count saturates, nothing reported
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b111, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b111, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b111, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b1, mkcc_pkg::KIND_NONE, 2'd0},
    // keys 0 and 2 expire together: the higher key wins
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b101, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b1, mkcc_pkg::KIND_SINGLE, 2'd2},
    // cap lowered below a running hold
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b001, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b001, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_CFG, mkcc_pkg::REG_HOLD_CAP, 8'd1, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b001, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b1, mkcc_pkg::KIND_SINGLE, 2'd0},
    // zero window leaves the count pending until a window is reloaded
    '{ROW_CFG, mkcc_pkg::REG_DOUBLE_WINDOW, 8'd0, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b010, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_CFG, mkcc_pkg::REG_DOUBLE_WINDOW, 8'd2, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b010, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b0, mkcc_pkg::KIND_NONE, 2'd0},
    '{ROW_TICK, mkcc_pkg::REG_PRESS_LEVEL, 8'd0, 3'b000, 1'b1, mkcc_pkg::KIND_DOUBLE, 2'd1}
  };

  logic clk = 1'b0;
  logic rst;
  logic sink_ready = 1'b0;

  mkcc_tick_if  keys_if();
  mkcc_event_if events_if();
  mkcc_cfg_if   cfg_if();

  assign events_if.ready = sink_ready;

  multi_key_click_classifier #(
    .NUM_KEYS(NUM_KEYS)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .keys  (keys_if),
    .events(events_if),
    .cfg   (cfg_if)
  );

  always #1 clk = ~clk;

  // Shadow registers and per-key lane state of the classifier
  mkcc_pkg::cfg_t               shadow;
  logic [mkcc_pkg::TICK_W-1:0]  hold_cnt  [NUM_KEYS];
  logic [mkcc_pkg::TICK_W-1:0]  win_cnt   [NUM_KEYS];
  logic [mkcc_pkg::COUNT_W-1:0] presses   [NUM_KEYS];
  logic                         long_lock [NUM_KEYS];

  mkcc_pkg::result_t pending_events [$];
  int                mismatches = 0;
  int                cycles = 0;

  // Receiver stall pattern
  logic [7:0] stall_pat  = 8'hFF;
  logic [2:0] stall_pos  = 3'd0;
  int         stall_left = 0;

  // Random key schedules: current direction and ticks left in it
  bit key_down  [NUM_KEYS];
  int span_left [NUM_KEYS];

  // Classify one tick and advance every lane
  function automatic mkcc_pkg::result_t classify_tick(
      input logic [mkcc_pkg::LEVEL_W-1:0] lv);
    mkcc_pkg::result_t         res;
    mkcc_pkg::kind_t           ev;
    logic [mkcc_pkg::TICK_W:0] nxt;
    res = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      ev = mkcc_pkg::KIND_NONE;
      if (lv[k] == shadow.press_level) begin
        nxt = {1'b0, hold_cnt[k]} + 1'b1;
        if (nxt >= {1'b0, shadow.hold_cap}) nxt = {1'b0, shadow.hold_cap};
        hold_cnt[k] = nxt[mkcc_pkg::TICK_W-1:0];
      end else begin
        if (hold_cnt[k] >= shadow.long_ticks && !long_lock[k]) begin
          ev = mkcc_pkg::KIND_LONG;
        end else if (hold_cnt[k] >= shadow.min_ticks) begin
          if (presses[k] != mkcc_pkg::COUNT_MAX) presses[k] = presses[k] + 1'b1;
          win_cnt[k]   = shadow.double_window;
          long_lock[k] = 1'b1;
        end
        hold_cnt[k] = '0;
        // count the window down on released ticks, report on expiry
        if (win_cnt[k] != 0) begin
          win_cnt[k] = win_cnt[k] - 1'b1;
          if (win_cnt[k] == 0) begin
            if (presses[k] == 2'd1) ev = mkcc_pkg::KIND_SINGLE;
            else if (presses[k] == 2'd2) ev = mkcc_pkg::KIND_DOUBLE;
            presses[k]   = '0;
            long_lock[k] = 1'b0;
          end
        end
      end
      if (ev != mkcc_pkg::KIND_NONE) begin
        res.event_kind = ev;
        res.event_key  = mkcc_pkg::KEY_W'(k);
      end
    end
    return res;
  endfunction

  // Pick a tick threshold: mostly typical, sometimes an extreme
  function automatic logic [mkcc_pkg::TICK_W-1:0] pick_ticks(input int lo, input int hi,
                                                              input bit zero_ok);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd1;
    if (r == 1) return 8'd255;
    if (r == 2 && zero_ok) return 8'd0;
    return mkcc_pkg::TICK_W'($urandom_range(hi, lo));
  endfunction

  // Send one tick, wait for it to be taken, queue its event
  task automatic send_tick(input logic [mkcc_pkg::LEVEL_W-1:0] lv, input bit typed,
                           input mkcc_pkg::kind_t kind,
                           input logic [mkcc_pkg::KEY_W-1:0] key);
    mkcc_pkg::result_t res;
    keys_if.valid      <= 1'b1;
    keys_if.key_levels <= lv;
    do @(posedge clk); while (!keys_if.ready);
    res = classify_tick(lv);
    if (typed) begin
      res.event_kind = kind;
      res.event_key  = key;
    end
    pending_events.push_back(res);
  endtask

  // Hold the sender until every queued event has come out
  task automatic drain_events();
    keys_if.valid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input logic [mkcc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mkcc_pkg::CFG_DATA_W-1:0] data);
    drain_events();
    repeat (2) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      mkcc_pkg::REG_PRESS_LEVEL:   shadow.press_level   = data[0];
      mkcc_pkg::REG_DOUBLE_WINDOW: shadow.double_window = data;
      mkcc_pkg::REG_LONG_TICKS:    shadow.long_ticks    = data;
      mkcc_pkg::REG_MIN_TICKS:     shadow.min_ticks     = data;
      mkcc_pkg::REG_HOLD_CAP:      shadow.hold_cap      = data;
      default: ;
    endcase
  endtask

  // Stall the receiver on a rotating pattern, reloaded now and then
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 2))
        0:       stall_pat <= 8'hFF;
        1:       stall_pat <= 8'($urandom) | 8'h01;
        default: stall_pat <= 8'h11;
      endcase
      stall_left <= $urandom_range(8, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_pos  <= stall_pos + 1'b1;
    sink_ready <= stall_pat[stall_pos];
  end

  // Compare each event with the oldest expectation
  always @(posedge clk) begin : check_events
    mkcc_pkg::result_t want;
    if (!rst && events_if.valid && events_if.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: event kind %0d key %0d arrived with no tick pending",
                 $time, events_if.event_kind, events_if.event_key);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (events_if.event_kind !== want.event_kind) begin
          $display("%0t: event_kind expected %0d, got %0d",
                   $time, want.event_kind, events_if.event_kind);
          mismatches++;
        end
        if (events_if.event_key !== want.event_key) begin
          $display("%0t: event_key expected %0d, got %0d",
                   $time, want.event_key, events_if.event_key);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [mkcc_pkg::LEVEL_W-1:0] lv;
    logic                         lvl;
    int                           gap;
    int                           burst_left;
    int                           hush_at;
    bit                           hushed;
    int                           mn;
    int                           lng;
    int                           win;
    int                           span;

    rst                <= 1'b1;
    keys_if.valid      <= 1'b0;
    keys_if.key_levels <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= '0;
    cfg_if.data        <= '0;

    shadow.press_level   = mkcc_pkg::RST_PRESS_LEVEL;
    shadow.double_window = mkcc_pkg::RST_DOUBLE_WINDOW;
    shadow.long_ticks    = mkcc_pkg::RST_LONG_TICKS;
    shadow.min_ticks     = mkcc_pkg::RST_MIN_TICKS;
    shadow.hold_cap      = mkcc_pkg::RST_HOLD_CAP;
    for (int k = 0; k < NUM_KEYS; k++) begin
      hold_cnt[k]  = '0;
      win_cnt[k]   = '0;
      presses[k]   = '0;
      long_lock[k] = 1'b0;
      key_down[k]  = 1'b0;
      span_left[k] = 0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].op == ROW_CFG) begin
        write_reg(DIR_TABLE[r].idx, DIR_TABLE[r].data);
      end else begin
        send_tick(DIR_TABLE[r].levels, DIR_TABLE[r].typed,
                  DIR_TABLE[r].kind, DIR_TABLE[r].key);
      end
    end

    // Random phases: new registers, then press sequences with noise
    burst_left = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      lvl = 1'($urandom_range(0, 1));
      if (ph == 0) begin
        write_reg(mkcc_pkg::REG_PRESS_LEVEL,   {7'd0, lvl});
        write_reg(mkcc_pkg::REG_DOUBLE_WINDOW, 8'd1);
        write_reg(mkcc_pkg::REG_LONG_TICKS,    8'd1);
        write_reg(mkcc_pkg::REG_MIN_TICKS,     8'd1);
        write_reg(mkcc_pkg::REG_HOLD_CAP,      8'd1);
      end else if (ph == 1) begin
        write_reg(mkcc_pkg::REG_PRESS_LEVEL,   {7'd0, lvl});
        write_reg(mkcc_pkg::REG_DOUBLE_WINDOW, 8'd255);
        write_reg(mkcc_pkg::REG_LONG_TICKS,    8'd255);
        write_reg(mkcc_pkg::REG_MIN_TICKS,     8'd255);
        write_reg(mkcc_pkg::REG_HOLD_CAP,      8'd255);
      end else begin
        write_reg(mkcc_pkg::REG_PRESS_LEVEL,   {7'd0, lvl});
        write_reg(mkcc_pkg::REG_DOUBLE_WINDOW, pick_ticks(1, 12, 1'b1));
        write_reg(mkcc_pkg::REG_LONG_TICKS,    pick_ticks(2, 25, 1'b0));
        write_reg(mkcc_pkg::REG_MIN_TICKS,     pick_ticks(1, 4, 1'b1));
        write_reg(mkcc_pkg::REG_HOLD_CAP,      pick_ticks(3, 40, 1'b1));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(mkcc_pkg::CFG_IDX_W'($urandom_range(2**mkcc_pkg::CFG_IDX_W - 1,
                                                      REG_UNUSED_FIRST)),
                  mkcc_pkg::CFG_DATA_W'($urandom));
      end

      mn      = shadow.min_ticks;
      lng     = shadow.long_ticks;
      win     = shadow.double_window;
      hush_at = $urandom_range(0, PHASE_LEN - 1);
      hushed  = 1'b0;

      for (int t = 0; t < PHASE_LEN; t++) begin
        // start a new burst after a gap, or once per phase after a full drain
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if (t >= hush_at && !hushed) begin
            hushed = 1'b1;
            drain_events();
          end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
              keys_if.valid <= 1'b0;
              repeat (gap) @(posedge clk);
            end
          end
        end
        burst_left--;

        // advance each key's press/release schedule
        for (int k = 0; k < NUM_KEYS; k++) begin
          if (span_left[k] == 0) begin
            key_down[k] = !key_down[k];
            if (key_down[k]) begin
              case ($urandom_range(0, 3))
                0:       span = $urandom_range(1, (mn > 1) ? mn - 1 : 1);
                1:       span = $urandom_range(mn, lng - 1);
                2:       span = $urandom_range(lng, lng + 3);
                default: span = $urandom_range(1, 6);
              endcase
            end else begin
              case ($urandom_range(0, 3))
                0:       span = $urandom_range(1, win);
                1:       span = $urandom_range(win, win + 4);
                2:       span = $urandom_range(1, 3);
                default: span = $urandom_range(20, 60);
              endcase
            end
            if (span == 0) span = 1;
            span_left[k] = span;
          end
          span_left[k]--;
          lv[k] = key_down[k] ? shadow.press_level : !shadow.press_level;
        end
        if ($urandom_range(0, 11) == 0) lv = lv ^ mkcc_pkg::LEVEL_W'($urandom);
        send_tick(lv, 1'b0, mkcc_pkg::KIND_NONE, '0);
      end
    end

    // Let every event come out, then allow a few more cycles
    drain_events();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
